// ===== src/lwss_pkg.sv =====
// Shared types and constants for the length weighted segment sampler.
// Holds command and status codes, stream field layout and the store control struct.
// No dependencies.
`default_nettype none

package lwss_pkg;

	// Command carried on the request tuser
	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_DRAW   = 2'd2
	} cmd_t;

	// Status carried on the result tuser
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Stream payload widths
	localparam int unsigned IN_DW  = 304;
	localparam int unsigned OUT_DW = 104;
	localparam int unsigned COORD_W = 32;
	localparam int unsigned TOTAL_W = 40;
	localparam int unsigned TARGET_W = 56;

	// Request field offsets inside tdata
	localparam int unsigned OFS_WEIGHT  = 192;
	localparam int unsigned OFS_U_PICK  = 224;
	localparam int unsigned OFS_U_ALONG = 240;
	localparam int unsigned OFS_JITTER  = 256;

	// Shared multiplier operand and product widths
	localparam int unsigned MUL_AW = 41;
	localparam int unsigned MUL_BW = 18;
	localparam int unsigned MUL_PW = 59;

	// Accumulator width for one interpolated axis
	localparam int unsigned ACC_W = 52;

	// Write strobes into the segment store
	typedef struct packed {
		logic ep_we;
		logic pf_we;
	} store_ctl_t;

endpackage

`default_nettype wire

// ===== src/lwss_mul.sv =====
// Shared signed multiplier with a registered product.
// Serves the draw target and all per-axis products; depends on lwss_pkg.
`default_nettype none

module lwss_mul (
	input  wire logic                                    clk,
	input  wire logic signed [lwss_pkg::MUL_AW-1:0]      a,
	input  wire logic signed [lwss_pkg::MUL_BW-1:0]      b,
	output logic signed      [lwss_pkg::MUL_PW-1:0]      prod_q
);
	import lwss_pkg::*;

	// Register every product before it is used
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

`default_nettype wire

// ===== src/lwss_store.sv =====
// Segment store: endpoint memory (six words per segment) and prefix memory.
// One write and one registered read port each; depends on lwss_pkg.
`default_nettype none

module lwss_store #(
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                                   clk,
	input  wire lwss_pkg::store_ctl_t                   ctl,
	input  wire logic [$clog2(6*DEPTH)-1:0]             ep_waddr,
	input  wire logic [lwss_pkg::COORD_W-1:0]           ep_wdata,
	input  wire logic [$clog2(6*DEPTH)-1:0]             ep_raddr,
	output logic      [lwss_pkg::COORD_W-1:0]           ep_rdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] pf_waddr,
	input  wire logic [lwss_pkg::TOTAL_W-1:0]           pf_wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] pf_raddr,
	output logic      [lwss_pkg::TOTAL_W-1:0]           pf_rdata
);
	import lwss_pkg::*;

	localparam int unsigned EP_DEPTH = 6 * DEPTH;

	logic [COORD_W-1:0] ep_mem [EP_DEPTH];
	logic [TOTAL_W-1:0] pf_mem [DEPTH];

	// Endpoint words: write and registered read
	always_ff @(posedge clk) begin
		if (ctl.ep_we) begin
			ep_mem[ep_waddr] <= ep_wdata;
		end
		ep_rdata <= ep_mem[ep_raddr];
	end

	// Prefix sums: write and registered read
	always_ff @(posedge clk) begin
		if (ctl.pf_we) begin
			pf_mem[pf_waddr] <= pf_wdata;
		end
		pf_rdata <= pf_mem[pf_raddr];
	end

endmodule

`default_nettype wire

// ===== src/length_weighted_segment_sampler.sv =====
// Top level of the length weighted segment sampler: sequencer, table state,
// output register. Depends on lwss_pkg, lwss_mul and lwss_store.
//
//  channel   | signals                      | moves
//  ----------+------------------------------+--------------------------------
//  request   | s_tvalid s_tready s_tdata    | command and segment / draw data
//            | s_tuser                      |
//  result    | m_tvalid m_tready m_tdata    | sampled point, segment, status
//            | m_tuser                      |
//  config    | cfg_we cfg_wdata             | jitter amplitude, Q16.16
//
// Clear, unused command, full append and empty draw go straight to the done
// state; an append writes six endpoint words through the single store write
// port; a draw runs a binary search on the prefix memory read, one step per
// index bit, then works each axis in turn on the shared multiplier and endpoint
// read port. The stores are not cleared after reset.
// A result waits in the output register while the next request is taken;
// the sequencer holds its finished result until that register is free.
`default_nettype none

module length_weighted_segment_sampler #(
	parameter int unsigned MAX_SEGMENTS = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// request
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// p_x, p_y, p_z, q_x, q_y, q_z, seg_weight, u_pick, u_along, jitter_draws
	input  wire logic [lwss_pkg::IN_DW-1:0]    s_tdata,
	// cmd
	input  wire logic [1:0]                    s_tuser,
	// result
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// out_x, out_y, out_z, chosen_segment
	output logic      [lwss_pkg::OUT_DW-1:0]   m_tdata,
	// status
	output logic      [1:0]                    m_tuser,
	// configuration
	input  wire logic                          cfg_we,
	input  wire logic [31:0]                   cfg_wdata
);
	import lwss_pkg::*;

	localparam int unsigned CW   = $clog2(MAX_SEGMENTS + 1);
	localparam int unsigned IDXW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int unsigned SBW  = (IDXW > 1) ? $clog2(IDXW) : 1;
	localparam int unsigned EPAW = $clog2(6 * MAX_SEGMENTS);

	typedef enum logic [3:0] {
		S_IDLE, S_APPEND, S_TGT, S_TLD, S_SRD, S_SCMP, S_BASE,
		S_RDP, S_RDQ, S_DIF, S_MUL1, S_MUL2, S_ADD, S_FIN, S_DONE
	} state_t;

	state_t                    state_q;
	logic [31:0]               eps_q;
	logic [CW-1:0]             count_q;
	logic [TOTAL_W-1:0]        total_q;
	logic [IN_DW-1:0]          in_q;
	logic [EPAW-1:0]           base_q;
	logic [2:0]                wr_idx_q;
	logic [TARGET_W-1:0]       target_q;
	logic [IDXW-1:0]           pos_q;
	logic [SBW-1:0]            bit_q;
	logic [1:0]                axis_q;
	logic [COORD_W-1:0]        p_q;
	logic signed [COORD_W:0]   diff_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic [COORD_W-1:0]        res_q [3];
	logic [7:0]                res_seg_q;
	logic [1:0]                res_st_q;
	logic                      m_tvalid_q;
	logic [OUT_DW-1:0]         m_tdata_q;
	logic [1:0]                m_tuser_q;

	// Datapath wires
	logic                      accept;
	logic                      out_free;
	logic                      is_full;
	logic [TOTAL_W:0]          total_sum;
	logic [IDXW-1:0]           cand;
	logic                      cand_ok;
	logic [15:0]               jit_u;
	logic signed [15:0]        jit_c;
	logic signed [35:0]        rnd;
	logic [COORD_W-1:0]        sat;
	logic signed [MUL_AW-1:0]  mul_a;
	logic signed [MUL_BW-1:0]  mul_b;
	logic signed [MUL_PW-1:0]  prod_q;
	store_ctl_t                st_ctl;
	logic [EPAW-1:0]           ep_waddr;
	logic [COORD_W-1:0]        ep_wdata;
	logic [EPAW-1:0]           ep_raddr;
	logic [COORD_W-1:0]        ep_rdata;
	logic [TOTAL_W-1:0]        pf_rdata;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign is_full   = (count_q >= CW'(MAX_SEGMENTS));
	assign total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(s_tdata[OFS_WEIGHT +: 32]);

	// Binary search candidate: current position with the next lower bit set
	assign cand    = pos_q | (IDXW'(1) << bit_q);
	assign cand_ok = (CW'(cand) < count_q) &&
	                 ({pf_rdata, 16'h0000} <= target_q);

	// Pick the jitter fraction of the current axis and center it on zero
	always_comb begin
		case (axis_q)
			2'd0:    jit_u = in_q[OFS_JITTER      +: 16];
			2'd1:    jit_u = in_q[OFS_JITTER + 16 +: 16];
			2'd2:    jit_u = in_q[OFS_JITTER + 32 +: 16];
			default: jit_u = '0;
		endcase
	end
	assign jit_c = {~jit_u[15], jit_u[14:0]};

	// Round half up is already folded in; drop the fraction and saturate
	assign rnd = acc_q[ACC_W-1:16];
	always_comb begin
		if (rnd[35:31] == 5'b00000 || rnd[35:31] == 5'b11111) begin
			sat = rnd[31:0];
		end else if (rnd[35]) begin
			sat = 32'h8000_0000;
		end else begin
			sat = 32'h7FFF_FFFF;
		end
	end

	// Select multiplier operands for the current step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_TGT: begin
				mul_a = {1'b0, total_q};
				mul_b = {2'b00, in_q[OFS_U_PICK +: 16]};
			end
			S_MUL1: begin
				mul_a = {{(MUL_AW-COORD_W-1){diff_q[COORD_W]}}, diff_q};
				mul_b = {2'b00, in_q[OFS_U_ALONG +: 16]};
			end
			S_MUL2: begin
				mul_a = {{(MUL_AW-32){1'b0}}, eps_q};
				mul_b = {{(MUL_BW-16){jit_c[15]}}, jit_c};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Drive the store write strobes and addresses
	always_comb begin
		st_ctl.pf_we = accept && (cmd_t'(s_tuser) == CMD_APPEND) && !is_full;
		st_ctl.ep_we = (state_q == S_APPEND);
		ep_waddr     = base_q + EPAW'(wr_idx_q);
		case (wr_idx_q)
			3'd0:    ep_wdata = in_q[0   +: 32];
			3'd1:    ep_wdata = in_q[32  +: 32];
			3'd2:    ep_wdata = in_q[64  +: 32];
			3'd3:    ep_wdata = in_q[96  +: 32];
			3'd4:    ep_wdata = in_q[128 +: 32];
			3'd5:    ep_wdata = in_q[160 +: 32];
			default: ep_wdata = '0;
		endcase
		if (state_q == S_RDQ) begin
			ep_raddr = base_q + EPAW'(axis_q) + EPAW'(3);
		end else begin
			ep_raddr = base_q + EPAW'(axis_q);
		end
	end

	lwss_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	lwss_store #(
		.DEPTH (MAX_SEGMENTS)
	) u_store (
		.clk      (clk),
		.ctl      (st_ctl),
		.ep_waddr (ep_waddr),
		.ep_wdata (ep_wdata),
		.ep_raddr (ep_raddr),
		.ep_rdata (ep_rdata),
		.pf_waddr (IDXW'(count_q)),
		.pf_wdata (total_q),
		.pf_raddr (cand),
		.pf_rdata (pf_rdata)
	);

	// Hold the jitter amplitude register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= '0;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	// Sequencer, table state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			total_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// Load a finished result or drop the one just taken
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						in_q      <= s_tdata;
						res_q[0]  <= '0;
						res_q[1]  <= '0;
						res_q[2]  <= '0;
						res_seg_q <= '0;
						wr_idx_q  <= '0;
						base_q    <= (EPAW'(count_q) << 2) + (EPAW'(count_q) << 1);
						case (cmd_t'(s_tuser))
							CMD_CLEAR: begin
								count_q  <= '0;
								total_q  <= '0;
								res_st_q <= ST_OK;
								state_q  <= S_DONE;
							end
							CMD_APPEND: begin
								if (is_full) begin
									res_st_q <= ST_FULL;
									state_q  <= S_DONE;
								end else begin
									count_q <= count_q + CW'(1);
									if (total_sum[TOTAL_W]) begin
										total_q <= '1;
									end else begin
										total_q <= total_sum[TOTAL_W-1:0];
									end
									res_st_q <= ST_OK;
									state_q  <= S_APPEND;
								end
							end
							CMD_DRAW: begin
								if (count_q == '0) begin
									res_st_q <= ST_EMPTY;
									state_q  <= S_DONE;
								end else begin
									res_st_q <= ST_OK;
									state_q  <= S_TGT;
								end
							end
							default: begin
								res_st_q <= ST_OK;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				// Write the six endpoint words one per cycle
				S_APPEND: begin
					wr_idx_q <= wr_idx_q + 3'd1;
					if (wr_idx_q == 3'd5) begin
						state_q <= S_DONE;
					end
				end
				S_TGT: begin
					state_q <= S_TLD;
				end
				S_TLD: begin
					target_q <= prod_q[TARGET_W-1:0];
					pos_q    <= '0;
					bit_q    <= SBW'(IDXW - 1);
					state_q  <= S_SRD;
				end
				S_SRD: begin
					state_q <= S_SCMP;
				end
				// Advance the search one index bit
				S_SCMP: begin
					if (cand_ok) begin
						pos_q <= cand;
					end
					if (bit_q == '0) begin
						state_q <= S_BASE;
					end else begin
						bit_q   <= bit_q - SBW'(1);
						state_q <= S_SRD;
					end
				end
				S_BASE: begin
					base_q  <= (EPAW'(pos_q) << 2) + (EPAW'(pos_q) << 1);
					axis_q  <= '0;
					state_q <= S_RDP;
				end
				S_RDP: begin
					state_q <= S_RDQ;
				end
				S_RDQ: begin
					p_q     <= ep_rdata;
					state_q <= S_DIF;
				end
				// Start from Q*65536 plus the rounding half
				S_DIF: begin
					diff_q  <= $signed({p_q[COORD_W-1], p_q}) -
					           $signed({ep_rdata[COORD_W-1], ep_rdata});
					acc_q   <= $signed({{(ACC_W-48){ep_rdata[COORD_W-1]}},
					                    ep_rdata, 16'h8000});
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					acc_q   <= acc_q + prod_q[ACC_W-1:0];
					state_q <= S_ADD;
				end
				// Jitter term counts twice
				S_ADD: begin
					acc_q   <= acc_q + $signed({prod_q[ACC_W-2:0], 1'b0});
					state_q <= S_FIN;
				end
				S_FIN: begin
					res_q[axis_q] <= sat;
					if (axis_q == 2'd2) begin
						res_seg_q <= 8'(pos_q);
						state_q   <= S_DONE;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_RDP;
					end
				end
				// Hand the result over once the output register is free
				S_DONE: begin
					if (out_free) begin
						m_tdata_q  <= {res_seg_q, res_q[2], res_q[1], res_q[0]};
						m_tuser_q  <= res_st_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
